@@ rtl/sscl_pkg.sv @@
// ----------------------------------------------------------------------------
// sscl_pkg: shared types and constants for screen select and clamp
// Item layouts, chain link record, mode and register codes.
// ----------------------------------------------------------------------------
package sscl_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int EXT_W      = 15;
  localparam int SLOT_W     = 3;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 4;
  localparam int CHOSEN_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived arithmetic widths
  localparam int EDGE_W = COORD_W + 2;           // rectangle edges
  localparam int DX_W   = COORD_W + 1;           // center distance per axis
  localparam int OV_W   = 2 * COORD_W;           // overlap area
  localparam int D_W    = 2 * DX_W + 1;          // squared distance

  // Token delay from the query accept to the first compare step:
  // the held query plus three score stages inside each cell
  localparam int LAT_STAGES = 4;

  // Defaults
  localparam int MAX_SCREENS_DEF = 8;
  localparam logic [EXT_W-1:0]   DEFAULT_TOP_BORDER = EXT_W'(48);
  localparam logic [COORD_W-1:0] ROOT_W_RESET       = COORD_W'(640);
  localparam logic [COORD_W-1:0] ROOT_H_RESET       = COORD_W'(480);

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD_BOUNDS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_WORK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY       = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_HEIGHT  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0]        width;
    logic [COORD_W-1:0]        height;
    logic [EXT_W-1:0]          ext_left;
    logic [EXT_W-1:0]          ext_right;
    logic [EXT_W-1:0]          ext_top;
    logic [EXT_W-1:0]          ext_bottom;
    logic                      extents_known;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] placed_x;
    logic signed [COORD_W-1:0] placed_y;
    logic [CHOSEN_W-1:0]       chosen_screen;
    logic                      used_fallback;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        w;
    logic [COORD_W-1:0]        h;
  } rect_t;

  // Table write request broadcast to all cells
  typedef struct packed {
    logic              load_bnd;
    logic              load_wa;
    logic [SLOT_W-1:0] slot;
    rect_t             rect;
  } wr_t;

  // Held query with borders resolved
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0]        width;
    logic [COORD_W-1:0]        height;
    logic [EXT_W-1:0]          el;
    logic [EXT_W-1:0]          er;
    logic [EXT_W-1:0]          et;
    logic [EXT_W-1:0]          eb;
  } query_t;

  // Running best handed from cell to cell
  typedef struct packed {
    logic            tok;
    logic [OV_W-1:0] ov;
    logic [D_W-1:0]  d;
    rect_t           wa;
  } link_t;

endpackage

@@ rtl/screen_select_and_clamp_top.sv @@
// A query is accepted only while busy is low; its result is marked by out_strobe,
// after which busy falls. Loads are accepted back to back while busy is low.
// A query passes three scoring stages, then the chain of cells, one entry
// compared per cycle, and then two placement stages.
// Reset clears the controls and sets screen_count 0, root area 640 by 480;
// table entries hold nothing defined until loaded. Results cannot be stalled.
// ----------------------------------------------------------------------------
// screen_select_and_clamp_top: screen selection and window placement
// Loads screen rectangles into a chain of cells, picks the screen that best
// covers a queried window and clamps the window into its work area.
// ----------------------------------------------------------------------------
module screen_select_and_clamp_top #(
  parameter int MAX_SCREENS = sscl_pkg::MAX_SCREENS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  sscl_pkg::in_item_t               in_item,
  output logic                             out_strobe,
  output sscl_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sscl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sscl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sscl_pkg::*;

  localparam int IDX_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;

  logic [CNT_W-1:0]   screen_count_r;
  logic [COORD_W-1:0] root_w_r;
  logic [COORD_W-1:0] root_h_r;
  logic               busy_r;
  logic [LAT_STAGES-1:0] lat_r;
  query_t             query_r;
  logic               accept, query_acc;
  wr_t                wr;

  link_t              links [MAX_SCREENS+1];
  logic [IDX_W-1:0]   idxs  [MAX_SCREENS+1];
  logic [MAX_SCREENS-1:0] cell_tok;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_count_r <= '0;
      root_w_r       <= ROOT_W_RESET;
      root_h_r       <= ROOT_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_COUNT: screen_count_r <= cfg_data[CNT_W-1:0];
        CFG_ROOT_WIDTH:   root_w_r       <= cfg_data[COORD_W-1:0];
        CFG_ROOT_HEIGHT:  root_h_r       <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept items while no query is in flight
  assign accept    = start && !busy_r;
  assign query_acc = accept && (in_item.mode == MODE_QUERY);

  // Broadcast table loads to the cells
  always_comb begin
    wr.load_bnd = accept && (in_item.mode == MODE_LOAD_BOUNDS);
    wr.load_wa  = accept && (in_item.mode == MODE_LOAD_WORK);
    wr.slot     = in_item.slot;
    wr.rect     = '{x: in_item.pos_x, y: in_item.pos_y,
                    w: in_item.width, h: in_item.height};
  end

  // Hold the query with its borders resolved
  always_ff @(posedge clk) begin
    if (query_acc) begin
      query_r.pos_x  <= in_item.pos_x;
      query_r.pos_y  <= in_item.pos_y;
      query_r.width  <= in_item.width;
      query_r.height <= in_item.height;
      query_r.el     <= in_item.extents_known ? in_item.ext_left   : '0;
      query_r.er     <= in_item.extents_known ? in_item.ext_right  : '0;
      query_r.et     <= in_item.extents_known ? in_item.ext_top    : DEFAULT_TOP_BORDER;
      query_r.eb     <= in_item.extents_known ? in_item.ext_bottom : '0;
    end
  end

  // Delay the start token until the cell scores are settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      lat_r <= {lat_r[LAT_STAGES-2:0], query_acc};
      if (query_acc) begin
        busy_r <= 1'b1;
      end else if (out_strobe) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;

  assign links[0] = '{tok: lat_r[LAT_STAGES-1], ov: '0, d: '0, wa: '0};
  assign idxs[0]  = '0;

  // Chain of screen cells
  for (genvar i = 0; i < MAX_SCREENS; i++) begin : g_cell
    sscl_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr           (wr),
      .query        (query_r),
      .screen_count (screen_count_r),
      .link_in      (links[i]),
      .idx_in       (idxs[i]),
      .link_out     (links[i+1]),
      .idx_out      (idxs[i+1])
    );
    assign cell_tok[i] = links[i+1].tok;
  end

  sscl_clamp #(
    .IDX_W (IDX_W)
  ) u_clamp (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_in    (links[MAX_SCREENS]),
    .idx_in     (idxs[MAX_SCREENS]),
    .fallback   (screen_count_r == '0),
    .root_w     (root_w_r),
    .root_h     (root_h_r),
    .query      (query_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef ASSERT_OFF
  a_query_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> busy_r)
    else $error("query accepted without raising busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy_r)
    else $error("result strobed with no query in flight");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({lat_r, cell_tok}))
    else $error("more than one query token in the chain");

  a_fallback_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.used_fallback) |-> (out_item.chosen_screen == '0))
    else $error("fallback result with nonzero screen index");
`endif

endmodule

@@ rtl/sscl_cell.sv @@
// ----------------------------------------------------------------------------
// sscl_cell: one screen entry of the selection chain
// Holds one bounds and work area rectangle, scores the held query against
// its bounds and passes on the better of its own score, if active, and the incoming best.
// ----------------------------------------------------------------------------
module sscl_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sscl_pkg::wr_t                wr,
  input  sscl_pkg::query_t             query,
  input  logic [sscl_pkg::CNT_W-1:0]   screen_count,
  input  sscl_pkg::link_t              link_in,
  input  logic [IDX_W-1:0]             idx_in,
  output sscl_pkg::link_t              link_out,
  output logic [IDX_W-1:0]             idx_out
);
  import sscl_pkg::*;

  rect_t bnd_r;
  rect_t wa_r;

  logic signed [EDGE_W-1:0] bx, by, br, bb, px, py, pr, pb;
  logic signed [EDGE_W-1:0] lft, top, rgt, bot, cx, cy, rr, rb;
  logic [COORD_W-1:0] ow, oh;
  logic [DX_W-1:0]    dx, dy;

  logic [COORD_W-1:0] ow_r, oh_r;
  logic [DX_W-1:0]    dx_r, dy_r;
  logic [OV_W-1:0]    ov2_r, ov_r;
  logic [2*DX_W-1:0]  dxx_r, dyy_r;
  logic [D_W-1:0]     d_r;

  logic sel, active, take;

  logic            tok_r;
  logic [OV_W-1:0] best_ov_r;
  logic [D_W-1:0]  best_d_r;
  rect_t           best_wa_r;
  logic [IDX_W-1:0] idx_r;

  // Store loads addressed to this entry
  assign sel = (int'(wr.slot) == CELL_IDX);

  always_ff @(posedge clk) begin
    if (wr.load_bnd && sel) begin
      bnd_r <= wr.rect;
    end
    if (wr.load_wa && sel) begin
      wa_r <= wr.rect;
    end
  end

  // Edges of the bounds and of the window, sign extended
  always_comb begin
    bx = {{2{bnd_r.x[COORD_W-1]}}, bnd_r.x};
    by = {{2{bnd_r.y[COORD_W-1]}}, bnd_r.y};
    br = bx + $signed({2'b00, bnd_r.w});
    bb = by + $signed({2'b00, bnd_r.h});
    px = {{2{query.pos_x[COORD_W-1]}}, query.pos_x};
    py = {{2{query.pos_y[COORD_W-1]}}, query.pos_y};
    pr = px + $signed({2'b00, query.width});
    pb = py + $signed({2'b00, query.height});

    // Overlap extent per axis
    lft = (bx > px) ? bx : px;
    top = (by > py) ? by : py;
    rgt = (br < pr) ? br : pr;
    bot = (bb < pb) ? bb : pb;
    ow  = ((rgt > lft) && (bot > top)) ? COORD_W'(rgt - lft) : '0;
    oh  = ((rgt > lft) && (bot > top)) ? COORD_W'(bot - top) : '0;

    // Distance from the window center to the bounds per axis
    cx = px + $signed({3'b000, query.width[COORD_W-1:1]});
    cy = py + $signed({3'b000, query.height[COORD_W-1:1]});
    rr = br - $signed(EDGE_W'(1));
    rb = bb - $signed(EDGE_W'(1));
    dx = (cx < bx) ? DX_W'(bx - cx) : ((cx > rr) ? DX_W'(cx - rr) : '0);
    dy = (cy < by) ? DX_W'(by - cy) : ((cy > rb) ? DX_W'(cy - rb) : '0);
  end

  // Score pipeline: extents, products, distance sum
  always_ff @(posedge clk) begin
    ow_r  <= ow;
    oh_r  <= oh;
    dx_r  <= dx;
    dy_r  <= dy;
    ov2_r <= OV_W'(ow_r) * OV_W'(oh_r);
    dxx_r <= (2*DX_W)'(dx_r) * (2*DX_W)'(dx_r);
    dyy_r <= (2*DX_W)'(dy_r) * (2*DX_W)'(dy_r);
    ov_r  <= ov2_r;
    d_r   <= D_W'(dxx_r) + D_W'(dyy_r);
  end

  // Active entries only: entry 0 always takes, others on a larger overlap, or equal overlap and closer center
  assign active = (int'(screen_count) > CELL_IDX);
  assign take   = active && ((CELL_IDX == 0) || (ov_r > link_in.ov) ||
                             ((ov_r == link_in.ov) && (d_r < link_in.d)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= link_in.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_ov_r <= ov_r;
      best_d_r  <= d_r;
      best_wa_r <= wa_r;
      idx_r     <= IDX_W'(CELL_IDX);
    end else begin
      best_ov_r <= link_in.ov;
      best_d_r  <= link_in.d;
      best_wa_r <= link_in.wa;
      idx_r     <= idx_in;
    end
  end

  assign link_out = '{tok: tok_r, ov: best_ov_r, d: best_d_r, wa: best_wa_r};
  assign idx_out  = idx_r;

endmodule

@@ rtl/sscl_clamp.sv @@
// ----------------------------------------------------------------------------
// sscl_clamp: placement of the window inside the chosen work area or the root area
// Forms the allowed range per axis less the borders, then clamps the
// preferred position and saturates it to the coordinate range.
// ----------------------------------------------------------------------------
module sscl_clamp #(
  parameter int IDX_W = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sscl_pkg::link_t               link_in,
  input  logic [IDX_W-1:0]              idx_in,
  input  logic                          fallback,
  input  logic [sscl_pkg::COORD_W-1:0]  root_w,
  input  logic [sscl_pkg::COORD_W-1:0]  root_h,
  input  sscl_pkg::query_t              query,
  output logic                          out_strobe,
  output sscl_pkg::out_item_t           out_item
);
  import sscl_pkg::*;

  localparam int SUM_W = COORD_W + 4;
  localparam int PAD   = SUM_W - COORD_W;
  localparam int EPAD  = SUM_W - EXT_W;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (COORD_W - 1)));

  logic signed [SUM_W-1:0] wx, wy, ww, wh;
  logic signed [SUM_W-1:0] lox, hix, loy, hiy;
  logic signed [SUM_W-1:0] lox_r, hix_r, loy_r, hiy_r, prefx_r, prefy_r;
  logic                    fb_r;
  logic [CHOSEN_W-1:0]     idx_r;
  logic                    va_r;
  logic                    str_r;
  out_item_t               item_r;

  // Clamp into [lo, hi], lo wins when the range is empty, then saturate
  function automatic logic [COORD_W-1:0] place(input logic signed [SUM_W-1:0] pref,
                                               input logic signed [SUM_W-1:0] lo,
                                               input logic signed [SUM_W-1:0] hi);
    logic signed [SUM_W-1:0] v;
    if (hi < lo) begin
      v = lo;
    end else if (pref < lo) begin
      v = lo;
    end else if (pref > hi) begin
      v = hi;
    end else begin
      v = pref;
    end
    if (v > SAT_HI) begin
      v = SAT_HI;
    end
    if (v < SAT_LO) begin
      v = SAT_LO;
    end
    return v[COORD_W-1:0];
  endfunction

  // Select the work area and form the ranges
  always_comb begin
    wx  = fallback ? '0 : {{PAD{link_in.wa.x[COORD_W-1]}}, link_in.wa.x};
    wy  = fallback ? '0 : {{PAD{link_in.wa.y[COORD_W-1]}}, link_in.wa.y};
    ww  = $signed({{PAD{1'b0}}, (fallback ? root_w : link_in.wa.w)});
    wh  = $signed({{PAD{1'b0}}, (fallback ? root_h : link_in.wa.h)});
    lox = wx + $signed({{EPAD{1'b0}}, query.el});
    loy = wy + $signed({{EPAD{1'b0}}, query.et});
    hix = wx + ww - $signed({{PAD{1'b0}}, query.width}) - $signed({{EPAD{1'b0}}, query.er});
    hiy = wy + wh - $signed({{PAD{1'b0}}, query.height}) - $signed({{EPAD{1'b0}}, query.eb});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      str_r <= 1'b0;
    end else begin
      va_r  <= link_in.tok;
      str_r <= va_r;
    end
  end

  // Hold ranges, then the placed item
  always_ff @(posedge clk) begin
    lox_r   <= lox;
    hix_r   <= hix;
    loy_r   <= loy;
    hiy_r   <= hiy;
    prefx_r <= {{PAD{query.pos_x[COORD_W-1]}}, query.pos_x};
    prefy_r <= {{PAD{query.pos_y[COORD_W-1]}}, query.pos_y};
    fb_r    <= fallback;
    idx_r   <= fallback ? '0 : CHOSEN_W'(idx_in);
    item_r.placed_x      <= place(prefx_r, lox_r, hix_r);
    item_r.placed_y      <= place(prefy_r, loy_r, hiy_r);
    item_r.chosen_screen <= idx_r;
    item_r.used_fallback <= fb_r;
  end

  assign out_strobe = str_r;
  assign out_item   = item_r;

endmodule
